// ----- rtl/bhc_pkg.sv -----
// bhc_pkg: shared item types, action codes and controller states for the
// byte histogram counter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bhc_pkg;

  // fixed widths of the item fields
  localparam int SYM_W = 8;
  localparam int OCC_W = 32;
  localparam logic [OCC_W-1:0] OCC_MAX = '1;

  // action codes
  localparam logic ACT_COUNT = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  typedef struct packed {
    logic             action;
    logic [SYM_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [OCC_W-1:0] occurrences;
    logic             found;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_READ = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/bhc_ram.sv -----
// bhc_ram: generic simple dual-port ram, one write port and one registered
// read port. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bhc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/bhc_update.sv -----
// bhc_update: read-modify-write stage for count items, saturating increment
// with forwarding of the previous write. Works against bhc_ram.
`timescale 1ns / 1ps
`default_nettype none

module bhc_update #(
  parameter int NUM_SYMBOLS = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cnt_en,
  input  wire logic [$clog2(NUM_SYMBOLS)-1:0] cnt_addr,
  input  wire logic [COUNT_WIDTH-1:0]         rd_data,
  output      logic [$clog2(NUM_SYMBOLS)-1:0] stage_addr,
  input  wire logic                           stage_live,
  output      logic                           wr_en,
  output      logic [$clog2(NUM_SYMBOLS)-1:0] wr_addr,
  output      logic [COUNT_WIDTH-1:0]         wr_data
);

  localparam int IDX_W = $clog2(NUM_SYMBOLS);

  logic                   stg_valid;
  logic [IDX_W-1:0]       stg_addr;
  logic                   fwd_valid;
  logic [IDX_W-1:0]       fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;
  logic [COUNT_WIDTH-1:0] bin_old;
  logic [COUNT_WIDTH-1:0] bin_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      stg_valid <= cnt_en;
      fwd_valid <= stg_valid;
    end
    stg_addr <= cnt_addr;
    fwd_addr <= stg_addr;
    fwd_data <= bin_new;
  end

  // cleared bins read as zero, a write at the read edge is forwarded
  always_comb begin
    if (!stage_live) begin
      bin_old = '0;
    end else if (fwd_valid && (fwd_addr == stg_addr)) begin
      bin_old = fwd_data;
    end else begin
      bin_old = rd_data;
    end
    bin_new = (&bin_old) ? bin_old : bin_old + COUNT_WIDTH'(1);
  end

  assign stage_addr = stg_addr;
  assign wr_en      = stg_valid;
  assign wr_addr    = stg_addr;
  assign wr_data    = bin_new;

endmodule

`default_nettype wire

// ----- rtl/byte_histogram_counter_core.sv -----
// byte_histogram_counter_core: top level of the byte histogram with ordered
// drain. Depends on bhc_pkg, bhc_ram and bhc_update.
`timescale 1ns / 1ps
`default_nettype none

// usage
//   an item is taken at a rising edge with start high and busy low
//   cmd.action = count: adds one to the bin of cmd.data_byte (saturating),
//     no result; bytes at or above NUM_SYMBOLS are dropped. count items go
//     one per cycle while busy is low; busy stays low for them
//   cmd.action = fetch: scans from the read cursor to the next non-zero bin,
//     reports symbol and count, clears that bin and moves the cursor past it.
//     when nothing is left it reports found = 0 and the cursor goes to zero
//   a fetch steps the cursor over empty bins until a presence bit is set or
//     the cursor reaches NUM_SYMBOLS; the scan checks one bin presence bit
//     per cycle, then reads the ram once when a bin is found
//   result is registered: result_valid pulses high for one cycle in the
//   same cycle that busy drops; the receiver cannot hold it off, and a new item
//   may be taken in that same cycle
//   reset (rst, synchronous) clears the bin presence bits, the cursor and
//   the controller at once: no clearing pass, the ram content is left as is
//   and bins without a presence bit read as zero
module byte_histogram_counter_core #(
  parameter int NUM_SYMBOLS = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output      logic               busy,
  input  wire bhc_pkg::in_item_t  cmd,
  output      bhc_pkg::out_item_t result,
  output      logic               result_valid
);

  localparam int IDX_W = $clog2(NUM_SYMBOLS);
  localparam int CUR_W = $clog2(NUM_SYMBOLS + 1);

  bhc_pkg::state_t    state;
  bhc_pkg::state_t    state_next;
  logic [CUR_W-1:0]   cursor;
  logic [CUR_W-1:0]   cursor_next;
  logic [IDX_W-1:0]   cur_idx;
  logic               at_end;
  // one presence bit per bin: set means the bin holds a non-zero count
  logic [NUM_SYMBOLS-1:0] bin_valid;

  logic               accept;
  logic               in_range;
  logic               cnt_en;
  logic               fetch_go;
  logic               clr_valid;
  logic               res_load;
  bhc_pkg::out_item_t res_next;

  logic [IDX_W-1:0]       ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_rdata;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic [IDX_W-1:0]       stage_addr;
  logic [63:0]            rd_wide;
  logic [bhc_pkg::OCC_W-1:0] occ_sat;

  // item handshake
  assign busy     = (state != bhc_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = ({1'b0, cmd.data_byte} < 9'(NUM_SYMBOLS));
  assign cnt_en   = accept && (cmd.action == bhc_pkg::ACT_COUNT) && in_range;
  assign fetch_go = accept && (cmd.action == bhc_pkg::ACT_FETCH);

  assign cur_idx = cursor[IDX_W-1:0];
  assign at_end  = (cursor >= CUR_W'(NUM_SYMBOLS));

  // scan owns the read port in the scan state, count items own it otherwise
  assign ram_raddr = (state == bhc_pkg::ST_SCAN) ? cur_idx : cmd.data_byte[IDX_W-1:0];

  // counts wider than the result field report as the saturated maximum
  assign rd_wide = 64'(ram_rdata);
  assign occ_sat = (|rd_wide[63:32]) ? bhc_pkg::OCC_MAX : rd_wide[31:0];

  bhc_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_SYMBOLS)
  ) u_bins (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bhc_update #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_update (
    .clk        (clk),
    .rst        (rst),
    .cnt_en     (cnt_en),
    .cnt_addr   (cmd.data_byte[IDX_W-1:0]),
    .rd_data    (ram_rdata),
    .stage_addr (stage_addr),
    .stage_live (bin_valid[stage_addr]),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  // fetch sequencer
  always_comb begin
    state_next  = state;
    cursor_next = cursor;
    res_load    = 1'b0;
    res_next    = '0;
    clr_valid   = 1'b0;
    case (state)
      bhc_pkg::ST_IDLE: begin
        if (fetch_go) begin
          state_next = bhc_pkg::ST_SCAN;
        end
      end
      bhc_pkg::ST_SCAN: begin
        if (at_end) begin
          // drained: report nothing found and rewind
          res_load    = 1'b1;
          cursor_next = '0;
          state_next  = bhc_pkg::ST_IDLE;
        end else if (bin_valid[cur_idx]) begin
          // ram read of this bin issues at this edge
          state_next = bhc_pkg::ST_READ;
        end else begin
          cursor_next = CUR_W'(cursor + 1'b1);
        end
      end
      bhc_pkg::ST_READ: begin
        res_load             = 1'b1;
        res_next.found       = 1'b1;
        res_next.symbol      = bhc_pkg::SYM_W'(cur_idx);
        res_next.occurrences = occ_sat;
        clr_valid            = 1'b1;
        cursor_next          = CUR_W'(cursor + 1'b1);
        state_next           = bhc_pkg::ST_IDLE;
      end
      default: begin
        state_next = bhc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bhc_pkg::ST_IDLE;
      cursor       <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cursor       <= cursor_next;
      result_valid <= res_load;
    end
    if (res_load) begin
      result <= res_next;
    end
  end

  // presence bits: set by a count write, cleared when the bin is handed out
  always_ff @(posedge clk) begin
    if (rst) begin
      bin_valid <= '0;
    end else begin
      if (wr_en) begin
        bin_valid[wr_addr] <= 1'b1;
      end
      if (clr_valid) begin
        bin_valid[cur_idx] <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_write_in_read: assert property (@(posedge clk) disable iff (rst)
    (state == bhc_pkg::ST_READ) |-> !wr_en)
    else $error("count write overlaps the fetch read");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.found) |-> (result.occurrences != '0))
    else $error("reported bin has zero count");

  a_drain_rewinds: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |-> (cursor == '0))
    else $error("cursor not rewound after drain");

  a_result_from_fetch: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == bhc_pkg::ST_SCAN || state == bhc_pkg::ST_READ))
    else $error("result without a fetch");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= CUR_W'(NUM_SYMBOLS))
    else $error("cursor beyond the bins");
`endif

endmodule

`default_nettype wire
